@@ rtl/core/base64_stream_codec_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Base64 stream codec
// Short wrappers that clock on clk and hold off while rst is high.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_CORE_ASSERT_SVH
`define BASE64_STREAM_CODEC_CORE_ASSERT_SVH

// Same-cycle check.
`define B64SC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on the cycle after the trigger.
`define B64SC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/b64sc_pkg.sv @@
// ---------------------------------------------------------------------------
// Base64 stream codec package
// Shared types, character codes and alphabet mapping functions.
// ---------------------------------------------------------------------------
`default_nettype none

package b64sc_pkg;

  localparam int Q_DEPTH = 2;

  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CHAR_D0    = 8'h30;
  localparam logic [7:0] CHAR_D9    = 8'h39;

  // One finished group: up to four result bytes, first in the high byte.
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
    logic        bad;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [5:0] val;
    logic       pad;
    logic       bad;
  } dec_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) return w + CHAR_UA;
    if (v < 6'd52) return w + (CHAR_LA - 8'd26);
    if (v < 6'd62) return w - (8'd52 - CHAR_D0);
    if (v == 6'd62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  function automatic dec_t char_to_sextet(input logic [7:0] c);
    dec_t r;
    r = '0;
    if (c inside {[CHAR_UA:CHAR_UZ]}) begin
      r.val = 6'(c - CHAR_UA);
    end else if (c inside {[CHAR_LA:CHAR_LZ]}) begin
      r.val = 6'(c - CHAR_LA + 8'd26);
    end else if (c inside {[CHAR_D0:CHAR_D9]}) begin
      r.val = 6'(c - CHAR_D0 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      r.val = 6'd62;
    end else if (c == CHAR_SLASH) begin
      r.val = 6'd63;
    end else if (c == CHAR_EQ) begin
      r.pad = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/b64sc_if.sv @@
// ---------------------------------------------------------------------------
// Base64 stream codec channels
// Valid/ready stream interfaces for the input and result sides.
// ---------------------------------------------------------------------------
`default_nettype none

interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_char;

  modport source (output valid, output out_byte, output out_last, output bad_char,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input bad_char,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/b64sc_front.sv @@
// ---------------------------------------------------------------------------
// Base64 codec front end
// Accepts input beats, gathers groups and converts each finished group.
// ---------------------------------------------------------------------------
`default_nettype none

module b64sc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_data,
  input  wire logic             room,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  output logic                  in_ready,
  output logic                  push,
  output b64sc_pkg::grp_t       push_data,
  output logic                  mode
);
  import b64sc_pkg::*;

  logic [23:0] gbits;
  logic [1:0]  fill;
  logic [1:0]  pads;
  logic        gbad;
  logic        direction;

  logic        accept;
  logic        complete;
  logic [23:0] merged;
  logic [1:0]  pads_next;
  logic        gbad_next;
  logic [1:0]  fill_next;

  logic [1:0]  epos;
  logic [1:0]  en;
  logic [2:0]  dn;
  dec_t        dc;
  logic [2:0]  padsum;
  logic [1:0]  padlim;
  logic [7:0]  chars [4];

  assign in_ready = room;
  assign accept   = in_valid && room;
  assign push     = accept && complete;
  assign mode     = direction;

  always_comb begin
    epos      = (fill > 2'd2) ? 2'd2 : fill;
    en        = epos + 2'd1;
    dn        = {1'b0, fill} + 3'd1;
    dc        = char_to_sextet(in_byte);
    merged    = gbits;
    pads_next = pads;
    gbad_next = gbad;
    fill_next = fill;
    complete  = 1'b0;
    padsum    = '0;
    padlim    = '0;
    push_data = '0;
    for (int k = 0; k < 4; k++) chars[k] = CHAR_EQ;

    if (!direction) begin
      case (epos)
        2'd0:    merged = gbits | {in_byte, 16'h0000};
        2'd1:    merged = gbits | {8'h00, in_byte, 8'h00};
        default: merged = gbits | {16'h0000, in_byte};
      endcase
      complete  = (en == 2'd3) || in_last;
      fill_next = en;
      // data-bearing characters: one more than the bytes gathered
      for (int k = 0; k < 4; k++) begin
        if (k <= int'(en)) chars[k] = sextet_to_char(merged[23 - 6 * k -: 6]);
      end
      push_data.data = {chars[0], chars[1], chars[2], chars[3]};
      push_data.cnt  = 3'd4;
      push_data.last = in_last;
      push_data.bad  = 1'b0;
    end else begin
      case (fill)
        2'd0:    merged = gbits | {dc.val, 18'h00000};
        2'd1:    merged = gbits | {6'h00, dc.val, 12'h000};
        2'd2:    merged = gbits | {12'h000, dc.val, 6'h00};
        default: merged = gbits | {18'h00000, dc.val};
      endcase
      if (dc.pad && pads != 2'd3) pads_next = pads + 2'd1;
      gbad_next = gbad | dc.bad;
      complete  = (dn == 3'd4) || in_last;
      fill_next = dn[1:0];
      // missing characters of a short final group count as padding
      padsum = {1'b0, pads_next} + (3'd4 - dn);
      padlim = (padsum > 3'd2) ? 2'd2 : padsum[1:0];
      push_data.data = {merged, 8'h00};
      push_data.cnt  = 3'd3 - {1'b0, padlim};
      push_data.last = in_last;
      push_data.bad  = gbad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      gbits     <= '0;
      fill      <= '0;
      pads      <= '0;
      gbad      <= 1'b0;
    end else if (cfg_we) begin
      // any config write drops any partial group
      direction <= cfg_data;
      gbits     <= '0;
      fill      <= '0;
      pads      <= '0;
      gbad      <= 1'b0;
    end else if (accept) begin
      if (complete) begin
        gbits <= '0;
        fill  <= '0;
        pads  <= '0;
        gbad  <= 1'b0;
      end else begin
        gbits <= merged;
        fill  <= fill_next;
        pads  <= pads_next;
        gbad  <= gbad_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64sc_queue.sv @@
// ---------------------------------------------------------------------------
// Base64 codec group queue
// Short FIFO of finished groups between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module b64sc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64sc_pkg::grp_t push_data,
  input  wire logic            pop,
  output b64sc_pkg::grp_t      pop_data,
  output b64sc_pkg::qstat_t    stat
);
  import b64sc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64sc_back.sv @@
// ---------------------------------------------------------------------------
// Base64 codec back end
// Takes finished groups from the queue and sends them out a beat at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module b64sc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b64sc_pkg::qstat_t stat,
  input  wire b64sc_pkg::grp_t   grp,
  output logic                   pop,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic                   bad_char
);
  import b64sc_pkg::*;

  logic        busy;
  logic [31:0] data;
  logic [2:0]  rem;
  logic        glast;
  logic        gbad;
  logic        advance;

  assign advance = !out_valid || out_ready;
  assign pop     = !busy && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (busy && advance && rem == 3'd1) begin
        busy <= 1'b0;
      end
      if (advance) out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data  <= grp.data;
      rem   <= grp.cnt;
      glast <= grp.last;
      gbad  <= grp.bad;
    end else if (busy && advance) begin
      // shift out the next byte, flag the final beat of a group marked last
      out_byte <= data[31:24];
      out_last <= glast && (rem == 3'd1);
      bad_char <= gbad;
      data     <= {data[23:0], 8'h00};
      rem      <= rem - 3'd1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/base64_stream_codec_core.sv @@
// Base64 stream codec (RFC 4648). cfg_data written with cfg_we selects encode (0) or
// decode (1); a write also drops any partial group. Input beats are taken one per
// cycle while the group queue has room; the back end loads each group from the queue
// and then sends one result beat per cycle while out_ready lets its output advance.
// Encoding sends 4 characters per 3 input bytes, decoding up to 3 bytes per 4
// characters. The queue holds QDEPTH finished groups so the input keeps flowing
// while results stall.
// ---------------------------------------------------------------------------
// Base64 stream codec top level
// Front end, group queue and back end with the stream and config ports.
// ---------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_codec_core_assert.svh"

module base64_stream_codec_core #(
  parameter int QDEPTH = b64sc_pkg::Q_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic     cfg_data,
  b64sc_in_if.sink      in_ch,
  b64sc_out_if.source   out_ch
);
  import b64sc_pkg::*;

  logic   q_push;
  logic   q_pop;
  grp_t   q_wdata;
  grp_t   q_rdata;
  qstat_t q_stat;
  logic   mode;

  b64sc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .room      (!q_stat.full),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .in_ready  (in_ch.ready),
    .push      (q_push),
    .push_data (q_wdata),
    .mode      (mode)
  );

  b64sc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  b64sc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (q_stat),
    .grp       (q_rdata),
    .pop       (q_pop),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last),
    .bad_char  (out_ch.bad_char)
  );

  `B64SC_ASSERT(a_push_room, q_push |-> !q_stat.full, "group pushed into a full queue")
  `B64SC_ASSERT(a_pop_avail, q_pop |-> !q_stat.empty, "group popped from an empty queue")
  `B64SC_ASSERT_NEXT(a_push_held, q_push, !q_stat.empty, "pushed group missing from queue")
  `B64SC_ASSERT(a_enc_clean, (out_ch.valid && !mode) |-> !out_ch.bad_char, "bad flag in encode")

endmodule

`default_nettype wire
